[design/btf_pkg.sv]
// Package for the bilinear texel filter: sizes, item codes, register indexes
// and the per-channel blend functions. Depends on nothing.
package btf_pkg;

    // Texel memory depth (a power of two) and coordinate fraction bits.
    localparam int TEXEL_DEPTH = 16384;
    localparam int FRAC_BITS   = 8;

    localparam int ADDR_W     = $clog2(TEXEL_DEPTH);
    localparam int TEXEL_W    = 32;
    localparam int CHAN_W     = 8;
    localparam int LERP_BITS  = 15;
    localparam int COORD_W    = 16;
    localparam int IDX_W      = 7;     // texture side is at most 128 texels
    localparam int LIN_W      = 14;    // linear texel index width
    localparam int LOG2_W     = 3;
    localparam int OUT_SLOTS  = 2;     // result buffer entries

    localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd7;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_SAMPLE = 1'b1
    } btf_kind_t;

    // Configuration register indexes.
    localparam logic CFG_WIDTH_LOG2  = 1'b0;
    localparam logic CFG_HEIGHT_LOG2 = 1'b1;

    // Order in which the four neighbours are read.
    localparam logic [1:0] SLOT_00 = 2'd0;
    localparam logic [1:0] SLOT_10 = 2'd1;
    localparam logic [1:0] SLOT_01 = 2'd2;
    localparam logic [1:0] SLOT_11 = 2'd3;

    // Memory request from the sequencer.
    typedef struct packed {
        logic                en;
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [TEXEL_W-1:0]  wdata;
    } btf_mem_req_t;

    // Tag that travels alongside each texel read.
    typedef struct packed {
        logic                 vld;
        logic [1:0]           slot;
        logic [LERP_BITS-1:0] fx;
        logic [LERP_BITS-1:0] fy;
    } btf_rd_tag_t;

    // Rounded multiply-high lerp on one 8-bit channel.
    function automatic logic [CHAN_W-1:0] lerp_chan(
        input logic [CHAN_W-1:0]    a,
        input logic [CHAN_W-1:0]    b,
        input logic [LERP_BITS-1:0] f
    );
        logic signed [CHAN_W:0]    d;
        logic signed [24:0]        prod;
        logic signed [9:0]         p;
        logic        [9:0]         sum;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = 25'(d * $signed({1'b0, f})) + 25'sd16384;
        p    = 10'(prod >>> LERP_BITS);
        sum  = 10'({2'b00, a}) + 10'(p);
        return sum[CHAN_W-1:0];
    endfunction

    // Lerp of all four channels of a packed texel.
    function automatic logic [TEXEL_W-1:0] lerp_texel(
        input logic [TEXEL_W-1:0]   a,
        input logic [TEXEL_W-1:0]   b,
        input logic [LERP_BITS-1:0] f
    );
        logic [TEXEL_W-1:0] r;
        r = '0;
        for (int ch = 0; ch < 4; ch++) begin
            r[ch*CHAN_W +: CHAN_W] = lerp_chan(a[ch*CHAN_W +: CHAN_W],
                                               b[ch*CHAN_W +: CHAN_W], f);
        end
        return r;
    endfunction

    // Linear texel index to memory address, modulo the depth.
    function automatic logic [ADDR_W-1:0] to_mem_addr(input logic [LIN_W-1:0] a);
        return ADDR_W'(a);
    endfunction

endpackage

[design/btf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
module btf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

[design/btf_issue.sv]
// Request sequencer: configuration registers, neighbour address generation
// and the one-access-per-cycle schedule of the texel memory. Uses btf_pkg.
module btf_issue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [btf_pkg::LOG2_W-1:0]      cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_kind,
    input  logic [btf_pkg::LIN_W-1:0]       s_texel_addr,
    input  logic [btf_pkg::TEXEL_W-1:0]     s_texel_value,
    input  logic [btf_pkg::COORD_W-1:0]     s_u_coord,
    input  logic [btf_pkg::COORD_W-1:0]     s_v_coord,
    input  logic                            credit_ok,
    output btf_pkg::btf_mem_req_t           mem_req,
    output btf_pkg::btf_rd_tag_t            rd_tag
);

    logic [btf_pkg::LOG2_W-1:0]    width_log2_reg, height_log2_reg;
    logic                          busy_reg, busy_next;
    logic                          sample_reg, sample_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic [btf_pkg::ADDR_W-1:0]    addr_reg [4];
    logic [btf_pkg::ADDR_W-1:0]    addr_next [4];
    logic [btf_pkg::TEXEL_W-1:0]   wdata_reg;
    logic [btf_pkg::LERP_BITS-1:0] fx_reg, fx_next, fy_reg, fy_next;

    logic                          last;
    logic                          s_accept;
    logic [btf_pkg::IDX_W-1:0]     wmask, hmask, ix, iy;
    logic [btf_pkg::COORD_W-1:0]   u_int, v_int;
    logic [btf_pkg::LIN_W-1:0]     a00, a10, a01, a11, row_step, down_step;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_log2_reg  <= btf_pkg::LOG2_RESET;
            height_log2_reg <= btf_pkg::LOG2_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                btf_pkg::CFG_WIDTH_LOG2:  width_log2_reg  <= cfg_data;
                btf_pkg::CFG_HEIGHT_LOG2: height_log2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // A sample holds the port until its four neighbour reads are issued, a write only for its own access.
    assign last     = !sample_reg || (cnt_reg == btf_pkg::SLOT_11);
    assign s_ready  = (!busy_reg || last) &&
                      ((s_kind == btf_pkg::KIND_WRITE) || credit_ok);
    assign s_accept = s_valid && s_ready;

    always_comb begin
        wmask     = btf_pkg::IDX_W'((8'd1 << width_log2_reg) - 8'd1);
        hmask     = btf_pkg::IDX_W'((8'd1 << height_log2_reg) - 8'd1);
        u_int     = s_u_coord >> btf_pkg::FRAC_BITS;
        v_int     = s_v_coord >> btf_pkg::FRAC_BITS;
        ix        = btf_pkg::IDX_W'(u_int) & wmask;
        iy        = btf_pkg::IDX_W'(v_int) & hmask;
        row_step  = btf_pkg::LIN_W'(1) << width_log2_reg;
        down_step = (iy != hmask) ? row_step : '0;
        a00       = btf_pkg::LIN_W'(ix) + (btf_pkg::LIN_W'(iy) << width_log2_reg);
        a10       = a00 + btf_pkg::LIN_W'(ix != wmask);
        a01       = a00 + down_step;
        a11       = a10 + down_step;
    end

    always_comb begin
        busy_next   = busy_reg;
        sample_next = sample_reg;
        cnt_next    = cnt_reg;
        addr_next   = addr_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        if (s_accept) begin
            busy_next   = 1'b1;
            sample_next = (s_kind == btf_pkg::KIND_SAMPLE);
            cnt_next    = btf_pkg::SLOT_00;
            fx_next     = btf_pkg::LERP_BITS'(s_u_coord[btf_pkg::FRAC_BITS-1:0])
                          << (btf_pkg::LERP_BITS - btf_pkg::FRAC_BITS);
            fy_next     = btf_pkg::LERP_BITS'(s_v_coord[btf_pkg::FRAC_BITS-1:0])
                          << (btf_pkg::LERP_BITS - btf_pkg::FRAC_BITS);
            if (s_kind == btf_pkg::KIND_SAMPLE) begin
                addr_next[btf_pkg::SLOT_00] = btf_pkg::to_mem_addr(a00);
                addr_next[btf_pkg::SLOT_10] = btf_pkg::to_mem_addr(a10);
                addr_next[btf_pkg::SLOT_01] = btf_pkg::to_mem_addr(a01);
                addr_next[btf_pkg::SLOT_11] = btf_pkg::to_mem_addr(a11);
            end else begin
                addr_next[btf_pkg::SLOT_00] = btf_pkg::to_mem_addr(s_texel_addr);
            end
        end else if (busy_reg && last) begin
            busy_next = 1'b0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            sample_reg <= 1'b0;
            cnt_reg    <= btf_pkg::SLOT_00;
        end else begin
            busy_reg   <= busy_next;
            sample_reg <= sample_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        if (s_accept) begin
            wdata_reg <= s_texel_value;
        end
    end

    always_comb begin
        mem_req.en    = busy_reg;
        mem_req.we    = !sample_reg;
        mem_req.addr  = addr_reg[cnt_reg];
        mem_req.wdata = wdata_reg;
        rd_tag.vld    = busy_reg && sample_reg;
        rd_tag.slot   = cnt_reg;
        rd_tag.fx     = fx_reg;
        rd_tag.fy     = fy_reg;
    end

endmodule

[design/btf_blend.sv]
// Blend datapath: gathers the four neighbours, lerps along rows then columns,
// buffers results and counts samples in flight. Uses btf_pkg.
module btf_blend (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  btf_pkg::btf_rd_tag_t           rd_tag,
    input  logic [btf_pkg::TEXEL_W-1:0]    rdata,
    input  logic                           sample_accept,
    output logic                           credit_ok,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [btf_pkg::CHAN_W-1:0]     m_red,
    output logic [btf_pkg::CHAN_W-1:0]     m_green,
    output logic [btf_pkg::CHAN_W-1:0]     m_blue,
    output logic [btf_pkg::CHAN_W-1:0]     m_alpha
);

    btf_pkg::btf_rd_tag_t          tag_reg;
    logic [btf_pkg::TEXEL_W-1:0]   c00_reg, c10_reg, c01_reg;
    logic [btf_pkg::TEXEL_W-1:0]   row1_reg, row2_reg;
    logic [btf_pkg::LERP_BITS-1:0] fy_reg;
    logic                          row_vld_reg;
    logic [btf_pkg::TEXEL_W-1:0]   fifo_reg [btf_pkg::OUT_SLOTS];
    logic                          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                    count_reg, count_next;
    logic [1:0]                    inflight_reg, inflight_next;
    logic                          m_xfer;
    logic [btf_pkg::TEXEL_W-1:0]   head;

    // Read data lines up with the registered tag in the cycle after the request.
    always_ff @(posedge aclk) begin
        tag_reg.slot <= rd_tag.slot;
        tag_reg.fx   <= rd_tag.fx;
        tag_reg.fy   <= rd_tag.fy;
        if (!aresetn) begin
            tag_reg.vld <= 1'b0;
            row_vld_reg <= 1'b0;
        end else begin
            tag_reg.vld <= rd_tag.vld;
            row_vld_reg <= tag_reg.vld && (tag_reg.slot == btf_pkg::SLOT_11);
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_reg.vld) begin
            case (tag_reg.slot)
                btf_pkg::SLOT_00: c00_reg <= rdata;
                btf_pkg::SLOT_10: c10_reg <= rdata;
                btf_pkg::SLOT_01: c01_reg <= rdata;
                btf_pkg::SLOT_11: begin
                    row1_reg <= btf_pkg::lerp_texel(c00_reg, c10_reg, tag_reg.fx);
                    row2_reg <= btf_pkg::lerp_texel(c01_reg, rdata, tag_reg.fx);
                    fy_reg   <= tag_reg.fy;
                end
                default: ;
            endcase
        end
    end

    assign m_xfer    = m_valid && m_ready;
    assign m_valid   = (count_reg != 2'd0);
    assign head      = fifo_reg[rd_ptr_reg];
    assign m_red     = head[0*btf_pkg::CHAN_W +: btf_pkg::CHAN_W];
    assign m_green   = head[1*btf_pkg::CHAN_W +: btf_pkg::CHAN_W];
    assign m_blue    = head[2*btf_pkg::CHAN_W +: btf_pkg::CHAN_W];
    assign m_alpha   = head[3*btf_pkg::CHAN_W +: btf_pkg::CHAN_W];
    assign credit_ok = (inflight_reg < 2'(btf_pkg::OUT_SLOTS));

    always_comb begin
        count_next    = count_reg + 2'(row_vld_reg) - 2'(m_xfer);
        inflight_next = inflight_reg + 2'(sample_accept) - 2'(m_xfer);
    end

    always_ff @(posedge aclk) begin
        if (row_vld_reg) begin
            fifo_reg[wr_ptr_reg] <= btf_pkg::lerp_texel(row1_reg, row2_reg, fy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            count_reg    <= 2'd0;
            inflight_reg <= 2'd0;
        end else begin
            if (row_vld_reg) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (m_xfer) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg    <= count_next;
            inflight_reg <= inflight_next;
        end
    end

endmodule

[design/bilinear_texel_filter.sv]
// Top level of the bilinear RGBA8 texel filter.
// Depends on btf_pkg, btf_ram, btf_issue and btf_blend.
//
//   Channel   Ports                                   Moves
//   --------  --------------------------------------  -----------------------------
//   cfg       cfg_valid/ready, cfg_index, cfg_data    width_log2 / height_log2 write
//   s         s_valid/ready, s_kind, s_texel_addr,    texel write or sample request
//             s_texel_value, s_u_coord, s_v_coord
//   m         m_valid/ready, m_red .. m_alpha         one filtered texel per sample
//
// A sample occupies the single-ported texel memory with one read per neighbour,
// and the next sample can be taken as its last read issues; a texel write occupies
// it for a single access. A result is registered through the neighbour reads,
// the row lerp and the result buffer. Reset clears the control state only:
// texel memory stays undefined until written, with no clearing pass. A stalled
// result channel is absorbed by a two-entry result buffer; once two samples are
// outstanding, further samples wait while texel writes still go through.
module bilinear_texel_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [btf_pkg::LOG2_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [btf_pkg::LIN_W-1:0]      s_texel_addr,
    input  logic [btf_pkg::TEXEL_W-1:0]    s_texel_value,
    input  logic [btf_pkg::COORD_W-1:0]    s_u_coord,
    input  logic [btf_pkg::COORD_W-1:0]    s_v_coord,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [btf_pkg::CHAN_W-1:0]     m_red,
    output logic [btf_pkg::CHAN_W-1:0]     m_green,
    output logic [btf_pkg::CHAN_W-1:0]     m_blue,
    output logic [btf_pkg::CHAN_W-1:0]     m_alpha
);

    btf_pkg::btf_mem_req_t          mem_req;
    btf_pkg::btf_rd_tag_t           rd_tag;
    logic [btf_pkg::TEXEL_W-1:0]    rdata;
    logic                           credit_ok;
    logic                           sample_accept;

    // Each accepted sample claims a result buffer entry until its transfer.
    assign sample_accept = s_valid && s_ready && (s_kind == btf_pkg::KIND_SAMPLE);

    // The sequencer owns the configuration and schedules every memory access
    // in transfer order, so a read that follows a write sees the new texel.
    btf_issue u_issue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_texel_addr  (s_texel_addr),
        .s_texel_value (s_texel_value),
        .s_u_coord     (s_u_coord),
        .s_v_coord     (s_v_coord),
        .credit_ok     (credit_ok),
        .mem_req       (mem_req),
        .rd_tag        (rd_tag)
    );

    // Texel memory: one access per cycle, read data registered for the next cycle.
    btf_ram #(
        .WIDTH (btf_pkg::TEXEL_W),
        .DEPTH (btf_pkg::TEXEL_DEPTH)
    ) u_texel_ram (
        .aclk  (aclk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (rdata)
    );

    // Row lerps when the last neighbour arrives, column lerp in the cycle after.
    btf_blend u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .rd_tag        (rd_tag),
        .rdata         (rdata),
        .sample_accept (sample_accept),
        .credit_ok     (credit_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha)
    );

endmodule

[sim/bilinear_texel_filter_tb.sv]
// Self-checking testbench for bilinear_texel_filter: texel writes and filtered samples
// are checked against a predictor that keeps its own texel store and size registers.
// Depends on btf_pkg and the bilinear_texel_filter RTL.
`timescale 1ns / 100ps

module bilinear_texel_filter_tb;

    localparam int N_PHASES      = 9;
    localparam int PHASE_ITEMS   = 220;   // minimum input transfers per random phase
    localparam int N_DIRECTED    = 19;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;   // long result-side stall
    localparam int STALL_LIMIT   = 5000;  // cycles with no transfer before giving up

    // One input transfer. When known is set, the expected filtered texel is typed in
    // by hand instead of being computed by the predictor.
    typedef struct packed {
        btf_pkg::btf_kind_t                kind;
        logic [btf_pkg::LIN_W-1:0]         addr;
        logic [btf_pkg::TEXEL_W-1:0]       value;
        logic [btf_pkg::COORD_W-1:0]       u;
        logic [btf_pkg::COORD_W-1:0]       v;
        logic                              known;
        logic [btf_pkg::TEXEL_W-1:0]       known_rgba;
    } stim_t;

    logic                              aclk;
    logic                              aresetn       = 1'b0;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_index     = btf_pkg::CFG_WIDTH_LOG2;
    logic [btf_pkg::LOG2_W-1:0]        cfg_data      = '0;
    logic                              s_valid       = 1'b0;
    logic                              s_ready;
    btf_pkg::btf_kind_t                s_kind        = btf_pkg::KIND_WRITE;
    logic [btf_pkg::LIN_W-1:0]         s_texel_addr  = '0;
    logic [btf_pkg::TEXEL_W-1:0]       s_texel_value = '0;
    logic [btf_pkg::COORD_W-1:0]       s_u_coord     = '0;
    logic [btf_pkg::COORD_W-1:0]       s_v_coord     = '0;
    logic                              m_valid;
    logic                              m_ready       = 1'b0;
    logic [btf_pkg::CHAN_W-1:0]        m_red;
    logic [btf_pkg::CHAN_W-1:0]        m_green;
    logic [btf_pkg::CHAN_W-1:0]        m_blue;
    logic [btf_pkg::CHAN_W-1:0]        m_alpha;

    // Predictor state: its own copy of texel memory and of the size registers.
    logic [btf_pkg::TEXEL_W-1:0]       texel_store [btf_pkg::TEXEL_DEPTH];
    logic [btf_pkg::LOG2_W-1:0]        width_log2_q  = btf_pkg::LOG2_RESET;
    logic [btf_pkg::LOG2_W-1:0]        height_log2_q = btf_pkg::LOG2_RESET;

    // Texels that the stimulus has already sent a write for. Samples are only built
    // over texels marked here, since memory is undefined until written.
    bit                                texel_planned [btf_pkg::TEXEL_DEPTH];

    logic [btf_pkg::TEXEL_W-1:0]       expected_rgba [$];
    stim_t                             cur_item;
    stim_t                             directed_rows [N_DIRECTED];
    string                             chan_name [4] = '{"red", "green", "blue", "alpha"};

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_request  = 1'b0;
    int  items_sent    = 0;
    int  stall_cycles  = 0;
    int  fail_count    = 0;
    int  texel_writes  = 0;
    int  samples_sent  = 0;
    int  results_seen  = 0;
    int  reg_writes    = 0;

    bilinear_texel_filter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_texel_addr  (s_texel_addr),
        .s_texel_value (s_texel_value),
        .s_u_coord     (s_u_coord),
        .s_v_coord     (s_v_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_alpha       (m_alpha)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Rounded multiply-high lerp on one channel: a + ((b - a) * f + 2^14) >> 15,
    // with the shift arithmetic so that negative steps round the same way.
    function automatic logic [btf_pkg::CHAN_W-1:0] blend_chan(
        input logic [btf_pkg::CHAN_W-1:0]    a,
        input logic [btf_pkg::CHAN_W-1:0]    b,
        input logic [btf_pkg::LERP_BITS-1:0] f
    );
        int step;
        step = (int'(b) - int'(a)) * int'(f) + (1 << (btf_pkg::LERP_BITS - 1));
        step = step >>> btf_pkg::LERP_BITS;
        return btf_pkg::CHAN_W'(int'(a) + step);
    endfunction

    // Memory addresses of the four neighbours of a sample point, indexed by the
    // package's read slots. x and y are wrapped by the texture size first, and the
    // right column and bottom row reuse themselves as their own neighbour.
    function automatic logic [3:0][btf_pkg::LIN_W-1:0] texel_corners(
        input logic [btf_pkg::COORD_W-1:0] u,
        input logic [btf_pkg::COORD_W-1:0] v,
        input int                          wl2,
        input int                          hl2
    );
        int w;
        int h;
        int ix;
        int iy;
        int a00;
        int a10;
        logic [3:0][btf_pkg::LIN_W-1:0] c;
        w   = 1 << wl2;
        h   = 1 << hl2;
        ix  = (int'(u) & ((w << btf_pkg::FRAC_BITS) - 1)) >> btf_pkg::FRAC_BITS;
        iy  = (int'(v) & ((h << btf_pkg::FRAC_BITS) - 1)) >> btf_pkg::FRAC_BITS;
        a00 = ix + (iy << wl2);
        a10 = a00 + ((ix < w - 1) ? 1 : 0);
        c[btf_pkg::SLOT_00] = btf_pkg::LIN_W'(a00);
        c[btf_pkg::SLOT_10] = btf_pkg::LIN_W'(a10);
        c[btf_pkg::SLOT_01] = btf_pkg::LIN_W'(a00 + ((iy < h - 1) ? w : 0));
        c[btf_pkg::SLOT_11] = btf_pkg::LIN_W'(a10 + ((iy < h - 1) ? w : 0));
        return c;
    endfunction

    // Filtered texel for a sample under the current size registers: blend along the
    // row first, then between the two rows.
    function automatic logic [btf_pkg::TEXEL_W-1:0] filter_texel(
        input logic [btf_pkg::COORD_W-1:0] u,
        input logic [btf_pkg::COORD_W-1:0] v
    );
        logic [3:0][btf_pkg::LIN_W-1:0]  c;
        logic [btf_pkg::TEXEL_W-1:0]     t00;
        logic [btf_pkg::TEXEL_W-1:0]     t10;
        logic [btf_pkg::TEXEL_W-1:0]     t01;
        logic [btf_pkg::TEXEL_W-1:0]     t11;
        logic [btf_pkg::LERP_BITS-1:0]   fx;
        logic [btf_pkg::LERP_BITS-1:0]   fy;
        logic [btf_pkg::CHAN_W-1:0]      upper;
        logic [btf_pkg::CHAN_W-1:0]      lower;
        logic [btf_pkg::TEXEL_W-1:0]     rgba;
        c   = texel_corners(u, v, width_log2_q, height_log2_q);
        t00 = texel_store[c[btf_pkg::SLOT_00]];
        t10 = texel_store[c[btf_pkg::SLOT_10]];
        t01 = texel_store[c[btf_pkg::SLOT_01]];
        t11 = texel_store[c[btf_pkg::SLOT_11]];
        fx  = btf_pkg::LERP_BITS'((int'(u) & ((1 << btf_pkg::FRAC_BITS) - 1))
                                  << (btf_pkg::LERP_BITS - btf_pkg::FRAC_BITS));
        fy  = btf_pkg::LERP_BITS'((int'(v) & ((1 << btf_pkg::FRAC_BITS) - 1))
                                  << (btf_pkg::LERP_BITS - btf_pkg::FRAC_BITS));
        for (int ch = 0; ch < 4; ch++) begin
            upper = blend_chan(t00[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W],
                               t10[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W], fx);
            lower = blend_chan(t01[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W],
                               t11[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W], fx);
            rgba[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W] = blend_chan(upper, lower, fy);
        end
        return rgba;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: register writes, result checks, input transfers and the stall count.
    // Results are checked before the input transfer of the same edge is predicted, so
    // the order of the two never depends on the simulator.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        logic [btf_pkg::TEXEL_W-1:0] want;
        logic [btf_pkg::TEXEL_W-1:0] got;
        logic                        moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                reg_writes++;
                case (cfg_index)
                    btf_pkg::CFG_WIDTH_LOG2:  width_log2_q  = cfg_data;
                    btf_pkg::CFG_HEIGHT_LOG2: height_log2_q = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                moved = 1'b1;
                got   = {m_alpha, m_blue, m_green, m_red};
                if (expected_rgba.size() == 0) begin
                    $error("result %08h arrived with no sample outstanding", got);
                    fail_count++;
                end else begin
                    want = expected_rgba.pop_front();
                    results_seen++;
                    for (int ch = 0; ch < 4; ch++) begin
                        if (want[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W] !==
                            got[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W]) begin
                            $error("%s: expected %02h, got %02h", chan_name[ch],
                                   want[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W],
                                   got[ch*btf_pkg::CHAN_W +: btf_pkg::CHAN_W]);
                            fail_count++;
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                moved = 1'b1;
                if (cur_item.kind == btf_pkg::KIND_WRITE) begin
                    texel_store[cur_item.addr] = cur_item.value;
                    texel_writes++;
                end else begin
                    expected_rgba.push_back(cur_item.known ? cur_item.known_rgba
                                                           : filter_texel(cur_item.u,
                                                                          cur_item.v));
                    samples_sent++;
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    // Watchdog: a long stretch with no transfer on any channel means the block hung.
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("bilinear_texel_filter_tb: FAIL");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request. The hold is
    // counted here so that the sender keeps offering items while results pile up.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) begin
                    m_ready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Called and returning at a falling edge. Valid may idle low first, then it rises
    // with the payload and stays put until the transfer.
    task automatic send_item(input stim_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        cur_item = it;
        if (it.kind == btf_pkg::KIND_WRITE) texel_planned[it.addr] = 1'b1;
        items_sent++;
        s_valid       <= 1'b1;
        s_kind        <= it.kind;
        s_texel_addr  <= it.addr;
        s_texel_value <= it.value;
        s_u_coord     <= it.u;
        s_v_coord     <= it.v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write.
    task automatic write_reg(input logic idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= btf_pkg::LOG2_W'(value);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Stops offering, waits until every sample has returned its texel and then lets the
    // pipeline run empty, so that trailing texel writes land before anything changes.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_rgba.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Texel values lean toward the channel extremes so that full-range blends show up.
    function automatic logic [btf_pkg::TEXEL_W-1:0] rand_texel();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h00FF_00FF;
            3:       return 32'hFF00_FF00;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_t make_row(input btf_pkg::btf_kind_t k, input int addr,
                                       input logic [btf_pkg::TEXEL_W-1:0] value,
                                       input int u, input int v, input bit known,
                                       input logic [btf_pkg::TEXEL_W-1:0] rgba);
        stim_t r;
        r.kind       = k;
        r.addr       = btf_pkg::LIN_W'(addr);
        r.value      = value;
        r.u          = btf_pkg::COORD_W'(u);
        r.v          = btf_pkg::COORD_W'(v);
        r.known      = known;
        r.known_rgba = rgba;
        return r;
    endfunction

    // One random step. Most steps are samples whose four neighbours are written first
    // when they have not been yet; the rest are stray writes anywhere in memory.
    task automatic random_step(input int wl2, input int hl2);
        int                             w;
        int                             h;
        int                             pick;
        stim_t                          it;
        stim_t                          fill;
        logic [3:0][btf_pkg::LIN_W-1:0] c;
        w    = 1 << wl2;
        h    = 1 << hl2;
        pick = $urandom_range(0, 99);
        it   = make_row(btf_pkg::KIND_SAMPLE, $urandom_range(0, btf_pkg::TEXEL_DEPTH - 1),
                        $urandom, $urandom_range(0, 65535), $urandom_range(0, 65535),
                        1'b0, '0);
        if (pick < 18) begin
            it.kind  = btf_pkg::KIND_WRITE;
            it.value = rand_texel();
            if (pick < 9) it.addr = btf_pkg::LIN_W'($urandom_range(0, w * h - 1));
            send_item(it);
        end else begin
            // Push a good share of samples onto the right column or the bottom row.
            if (pick < 45) begin
                if ($urandom_range(0, 1))
                    it.u = it.u | btf_pkg::COORD_W'((w - 1) << btf_pkg::FRAC_BITS);
                if ($urandom_range(0, 1))
                    it.v = it.v | btf_pkg::COORD_W'((h - 1) << btf_pkg::FRAC_BITS);
            end
            // Zero and full fractions now and then.
            if ($urandom_range(0, 4) == 0)
                it.u[btf_pkg::FRAC_BITS-1:0] = btf_pkg::FRAC_BITS'(
                    $urandom_range(0, 1) * ((1 << btf_pkg::FRAC_BITS) - 1));
            if ($urandom_range(0, 4) == 0)
                it.v[btf_pkg::FRAC_BITS-1:0] = btf_pkg::FRAC_BITS'(
                    $urandom_range(0, 1) * ((1 << btf_pkg::FRAC_BITS) - 1));
            c = texel_corners(it.u, it.v, wl2, hl2);
            for (int k = 0; k < 4; k++) begin
                if (!texel_planned[c[k]]) begin
                    fill       = it;
                    fill.kind  = btf_pkg::KIND_WRITE;
                    fill.addr  = c[k];
                    fill.value = rand_texel();
                    send_item(fill);
                end
            end
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int wl2;
        int hl2;
        int target;
        int phase_wl2 [N_PHASES];
        int phase_hl2 [N_PHASES];
        phase_wl2 = '{7, 0, 4, 7, 0, 2, 5, 1, 0};
        phase_hl2 = '{7, 0, 2, 0, 7, 6, 5, 3, 0};

        // Directed table, run under the reset size of 128 x 128 texels. The corner
        // texels of the first 2 x 2 block hold opposite extremes so that both rising
        // and falling blends are exercised. Rows with f = 0, or with all four neighbours
        // clamped onto one texel, return that texel unchanged and are typed in.
        directed_rows[0]  = make_row(btf_pkg::KIND_WRITE,  0,     32'hFF00_FF00,
                                     0, 0, 0, '0);
        directed_rows[1]  = make_row(btf_pkg::KIND_WRITE,  1,     32'h00FF_00FF,
                                     0, 0, 0, '0);
        directed_rows[2]  = make_row(btf_pkg::KIND_WRITE,  128,   32'h0000_0000,
                                     0, 0, 0, '0);
        directed_rows[3]  = make_row(btf_pkg::KIND_WRITE,  129,   32'hFFFF_FFFF,
                                     0, 0, 0, '0);
        directed_rows[4]  = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h0000, 16'h0000,
                                     1, 32'hFF00_FF00);
        directed_rows[5]  = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h0080, 16'h0000,
                                     0, '0);
        directed_rows[6]  = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h00FF, 16'h00FF,
                                     0, '0);
        directed_rows[7]  = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h0080, 16'h0080,
                                     0, '0);
        directed_rows[8]  = make_row(btf_pkg::KIND_WRITE,  16383, 32'h8040_2010,
                                     0, 0, 0, '0);
        // Top coordinate bits wrap away; x and y both sit on the clamped edges.
        directed_rows[9]  = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'hFFFF, 16'hFFFF,
                                     1, 32'h8040_2010);
        directed_rows[10] = make_row(btf_pkg::KIND_WRITE,  127,   32'h1234_5678,
                                     0, 0, 0, '0);
        directed_rows[11] = make_row(btf_pkg::KIND_WRITE,  255,   32'h0000_0000,
                                     0, 0, 0, '0);
        // Right column: the right neighbour is the texel itself.
        directed_rows[12] = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h7F80, 16'h0000,
                                     0, '0);
        directed_rows[13] = make_row(btf_pkg::KIND_WRITE,  16256, 32'h0000_FFFF,
                                     0, 0, 0, '0);
        directed_rows[14] = make_row(btf_pkg::KIND_WRITE,  16257, 32'hFFFF_0000,
                                     0, 0, 0, '0);
        // Bottom row: the lower neighbour is the row itself.
        directed_rows[15] = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h0040, 16'h7F40,
                                     0, '0);
        directed_rows[16] = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h8080, 16'h8000,
                                     0, '0);
        directed_rows[17] = make_row(btf_pkg::KIND_WRITE,  0,     32'hFFFF_FFFF,
                                     0, 0, 0, '0);
        directed_rows[18] = make_row(btf_pkg::KIND_SAMPLE, 0, 0, 16'h0000, 16'h0000,
                                     1, 32'hFFFF_FFFF);

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 32;
        recv_idle_pct = 78;
        for (int r = 0; r < N_DIRECTED; r++) send_item(directed_rows[r]);
        drain_results();

        // Random phases. Each one sets a texture size while the block is idle, then
        // streams items. Idling goes sender-light / receiver-heavy, then the reverse,
        // then none, and one phase without idling starts with the long result stall.
        for (int p = 0; p < N_PHASES; p++) begin
            wl2 = phase_wl2[p];
            hl2 = phase_hl2[p];
            if (p == N_PHASES - 1) begin
                wl2 = $urandom_range(0, 7);
                hl2 = $urandom_range(0, 7);
            end
            write_reg(btf_pkg::CFG_WIDTH_LOG2, wl2);
            write_reg(btf_pkg::CFG_HEIGHT_LOG2, hl2);
            cfg_valid <= 1'b0;
            if (p < 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 78;
            end else if (p < 6) begin
                send_idle_pct = 78;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 7) hold_request = 1'b1;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) random_step(wl2, hl2);
            drain_results();
        end

        $display("Covered %0d texel writes and %0d samples (%0d results checked) over",
                 texel_writes, samples_sent, results_seen);
        $display("  %0d size register writes, both edge clamps and a long output stall.",
                 reg_writes);
        if (fail_count == 0) begin
            $display("bilinear_texel_filter_tb: PASS");
        end else begin
            $display("bilinear_texel_filter_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
design/btf_pkg.sv
design/btf_ram.sv
design/btf_issue.sv
design/btf_blend.sv
design/bilinear_texel_filter.sv
sim/bilinear_texel_filter_tb.sv
